// ----- rtl/mau_pkg.sv -----
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared widths, opcodes and payload types.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int unsigned ModW       = 31;
  localparam int unsigned OpW        = 3;
  localparam int unsigned DefWidth   = 32;
  localparam int unsigned AddrW      = 1;

  typedef enum logic [OpW-1:0] {
    OP_NORM = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_INV  = 3'd4,
    OP_DIV  = 3'd5
  } opcode_e;

  localparam logic [AddrW-1:0] RegModulus = 1'b0;

  typedef struct packed {
    logic [ModW-1:0] result;
    logic            no_inverse;
  } res_t;

endpackage

// ----- rtl/mau_if.sv -----
// ----------------------------------------------------------------------------
// Valid/ready channel
// One channel carrying an opcode, operands or a result.
// ----------------------------------------------------------------------------
interface mau_req_if #(parameter int unsigned Width = 32) ();
  logic                    valid;
  logic                    ready;
  logic [2:0]              opcode;
  logic signed [Width-1:0] operand_a;
  logic signed [Width-1:0] operand_b;
  modport source (output valid, opcode, operand_a, operand_b, input ready);
  modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface mau_rsp_if ();
  logic        valid;
  logic        ready;
  logic [30:0] result;
  logic        no_inverse;
  modport source (output valid, result, no_inverse, input ready);
  modport sink   (input valid, result, no_inverse, output ready);
endinterface

// ----- rtl/mau_divider.sv -----
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned quotient and remainder, one bit per cycle.
// ----------------------------------------------------------------------------
module mau_divider #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         busy_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    quo_q, rem_q, den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [W:0]      trial;

  assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      // shift in next dividend bit; keep the trial difference if it fits
      if (!trial[W] || rem_q[W-1]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[W-2:0], quo_q[W-1]};
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/mau_core.sv -----
// ----------------------------------------------------------------------------
// Modular arithmetic sequencer
// Reduces operands on one shared bit-serial divider, which also runs mul,
// inverse and divide; add and sub use the reduced operands directly.
// ----------------------------------------------------------------------------
module mau_core
  import mau_pkg::*;
#(
  parameter int unsigned Width = DefWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ModW-1:0]     modulus_i,
  input  logic                start_i,
  input  logic [OpW-1:0]      opcode_i,
  input  logic [Width-1:0]    a_i,
  input  logic [Width-1:0]    b_i,
  output logic                done_o,
  output res_t                res_o
);

  // divider wide enough for operand magnitudes and 62-bit products
  localparam int unsigned DW   = (Width > 2*ModW) ? Width : 2*ModW;

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RA_W, S_RB, S_RB_W, S_OP, S_MUL_W, S_EU, S_EU_W, S_FIN_INV,
    S_FIN_DIV, S_DONE
  } state_e;

  state_e          state_q;
  logic [OpW-1:0]  op_q;
  logic [Width-1:0] a_raw_q, b_raw_q;
  logic [ModW-1:0] m_q, a_q, b_q;
  // Euclid state
  logic [ModW-1:0] or_q, r_q;
  logic signed [ModW+1:0] os_q, s_q;
  res_t            res_q;
  logic            done_q;

  // shared divider, driven by the sequencer
  logic [DW-1:0]   div_quo, div_rem;
  logic            div_busy;
  logic            dstart;
  logic [DW-1:0]   dnum, dden;

  function automatic logic [Width-1:0] mag_f(input logic [Width-1:0] x);
    return x[Width-1] ? (~x + 1'b1) : x;
  endfunction

  // remainder fix for negative operands
  function automatic logic [ModW-1:0] fix_f(input logic [ModW-1:0] r, input logic neg,
                                            input logic [ModW-1:0] m);
    return (neg && r != '0) ? m - r : r;
  endfunction

  logic [2*ModW-1:0] prod;
  logic [ModW:0]     sum;
  logic [ModW:0]     dif;
  logic [ModW-1:0]   remn;
  logic signed [2*ModW+3:0] qs;
  logic signed [ModW+1:0] ns;

  assign remn = div_rem[ModW-1:0];
  assign sum  = {1'b0, a_q} + {1'b0, b_q};
  assign dif  = {1'b0, a_q} + {1'b0, m_q} - {1'b0, b_q};
  // product of a and b or a and inverse, only one 31x31 multiplier
  assign prod = a_q * ((op_q == OP_MUL) ? b_q : or_q);
  assign qs   = $signed({2'b00, div_quo[ModW-1:0]}) * s_q;
  assign ns   = os_q - (ModW+2)'(qs);

  always_comb begin
    dstart = 1'b0;
    dnum   = '0;
    dden   = DW'(m_q);
    case (state_q)
      S_RA: begin dstart = 1'b1; dnum = DW'(mag_f(a_raw_q)); end
      S_RB: begin dstart = 1'b1; dnum = DW'(mag_f(b_raw_q)); end
      S_OP: begin
        dstart = (op_q == OP_MUL) || (op_q == OP_INV) || (op_q == OP_DIV);
        dnum   = (op_q == OP_MUL) ? DW'(prod) : DW'(a_q);
        if (op_q == OP_DIV) dnum = DW'(b_q);
      end
      S_EU: begin dstart = 1'b1; dnum = DW'(or_q); dden = DW'(r_q); end
      S_FIN_DIV: begin dstart = 1'b1; dnum = DW'(prod); end
      default: ;
    endcase
  end

  mau_divider #(.W(DW)) u_div (
    .clk_i,
    .rst_ni,
    .start_i(dstart),
    .num_i  (dnum),
    .den_i  (dden),
    .busy_o (div_busy),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      done_q     <= 1'b0;
    end else begin
      done_q <= (state_q == S_DONE);
      case (state_q)
        S_IDLE: if (start_i) begin
          state_q <= S_RA;
          op_q    <= opcode_i;
          a_raw_q <= a_i;
          b_raw_q <= b_i;
          m_q     <= (modulus_i == '0) ? ModW'(1) : modulus_i;
        end
        S_RA: state_q <= S_RA_W;
        S_RA_W: if (!div_busy) begin
          a_q     <= fix_f(remn, a_raw_q[Width-1], m_q);
          state_q <= S_RB;
        end
        S_RB: state_q <= S_RB_W;
        S_RB_W: if (!div_busy) begin
          b_q     <= fix_f(remn, b_raw_q[Width-1], m_q);
          state_q <= S_OP;
        end
        S_OP: begin
          res_q.no_inverse <= 1'b0;
          // Euclid start: old_r = x, r = m, old_s = 1, s = 0
          or_q <= (op_q == OP_DIV) ? b_q : a_q;
          r_q  <= m_q;
          os_q <= (ModW+2)'(1);
          s_q  <= '0;
          case (op_q)
            OP_NORM: begin res_q.result <= a_q; state_q <= S_DONE; end
            OP_ADD: begin
              res_q.result <= (sum >= {1'b0, m_q}) ? ModW'(sum - {1'b0, m_q}) : sum[ModW-1:0];
              state_q <= S_DONE;
            end
            OP_SUB: begin
              res_q.result <= (dif >= {1'b0, m_q}) ? ModW'(dif - {1'b0, m_q}) : dif[ModW-1:0];
              state_q <= S_DONE;
            end
            OP_MUL: begin res_q.result <= '0; state_q <= S_MUL_W; end
            OP_INV, OP_DIV: begin res_q.result <= '0; state_q <= S_EU; end
            default: begin res_q.result <= '0; state_q <= S_DONE; end
          endcase
        end
        S_MUL_W: if (!div_busy) begin
          res_q.result <= remn;
          state_q      <= S_DONE;
        end
        S_EU: begin
          if (r_q == '0) state_q <= S_FIN_INV;
          else state_q <= S_EU_W;
        end
        S_EU_W: if (!div_busy) begin
          or_q    <= r_q;
          r_q     <= remn;
          os_q    <= s_q;
          s_q     <= ns;
          state_q <= S_EU;
        end
        S_FIN_INV: begin
          // old_s lies in (-m, m); fold into [0, m)
          if (or_q != ModW'(1)) begin
            res_q.no_inverse <= 1'b1;
            state_q          <= S_DONE;
          end else begin
            or_q <= (m_q == ModW'(1)) ? '0 :
              (os_q[ModW+1] ? ModW'(os_q + (ModW+2)'(m_q)) : ModW'(os_q));
            if (op_q == OP_DIV) state_q <= S_FIN_DIV;
            else begin
              res_q.result <= (m_q == ModW'(1)) ? '0 :
                (os_q[ModW+1] ? ModW'(os_q + (ModW+2)'(m_q)) : ModW'(os_q));
              state_q <= S_DONE;
            end
          end
        end
        S_FIN_DIV: state_q <= S_MUL_W;
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE) else $error("start while busy");
  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (res_q.result < m_q)) else $error("result not reduced");
  a_fail_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.no_inverse) |-> (op_q == OP_INV || op_q == OP_DIV && res_q.result == '0))
    else $error("bad failure flag");
`endif

endmodule

// ----- rtl/modular_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Normalize, add, subtract, multiply, inverse and divide under a modulus.
// ----------------------------------------------------------------------------
// Usage: write the modulus over APB (address 0) while idle; reset sets it to
// one, and zero acts as one. Send requests on req (opcode, operand_a,
// operand_b); each yields one transfer on rsp with result and no_inverse.
// One item at a time: req_ready is high only while no item is in flight or
// waiting. The time from the req transfer to rsp valid is set by the
// passes of the shared bit-serial divider: normalize/add/sub reduce both
// operands, multiply adds a pass, inverse adds one per Euclid step and
// divide one more on top; the next request is taken once rsp transfers.
// A stalled receiver holds the result in the output register and keeps
// req_ready low until the transfer completes. Reset clears all control
// state and drops any item in flight.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit
  import mau_pkg::*;
#(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  mau_req_if.sink           req,
  mau_rsp_if.source         rsp
);

  logic [ModW-1:0] modulus_q;
  logic            busy_q, out_v_q, done;
  res_t            res, out_q;
  logic            start;

  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == RegModulus) ? {1'b0, modulus_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) modulus_q <= ModW'(1);
    else if (psel && penable && pwrite && paddr[2:2] == RegModulus)
      modulus_q <= pwdata[ModW-1:0];
  end

  assign req.ready = !busy_q && !out_v_q;
  assign start     = req.valid && req.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (start) busy_q <= 1'b1;
      if (done) begin
        busy_q  <= 1'b0;
        out_v_q <= 1'b1;
      end else if (rsp.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) if (done) out_q <= res;

  assign rsp.valid      = out_v_q;
  assign rsp.result     = out_q.result;
  assign rsp.no_inverse = out_q.no_inverse;

  mau_core #(.Width(WIDTH)) u_core (
    .clk_i, .rst_ni,
    .modulus_i(modulus_q),
    .start_i(start),
    .opcode_i(req.opcode),
    .a_i(req.operand_a),
    .b_i(req.operand_b),
    .done_o(done),
    .res_o(res)
  );

`ifndef SYNTHESIS
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && out_v_q)) else $error("overlap of busy and pending result");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy_q) else $error("done without item");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.result))
    else $error("result dropped");
`endif

endmodule
